// ===== rtl/core/asc_pkg.sv =====
package asc_pkg;

    localparam int ONE_G_SCALE    = 4096;
    localparam int SAVE_INTERVAL  = 100;
    localparam int THRESH_DIVISOR = 200;
    localparam int RATE_NUMERATOR = 960000;
    localparam int THRESH_RESET   = 45;

    localparam int RATE_W  = 20;
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = RATE_W;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int SAVE_W  = $clog2(SAVE_INTERVAL + 1);
    localparam int CMP_W   = $clog2(65536 * THRESH_DIVISOR + ONE_G_SCALE * THRESH_DIVISOR
                                    + 256 * ONE_G_SCALE) + 1;
    localparam int ONE_TERM = ONE_G_SCALE * THRESH_DIVISOR;

    localparam logic REG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [31:0]        timestamp_ms;
    } asc_in_t;

    typedef struct packed {
        logic [31:0]       step_total;
        logic              step_seen;
        logic              save_due;
        logic [RATE_W-1:0] step_rate;
        logic              rate_valid;
        logic [15:0]       smoothed_magnitude;
    } asc_out_t;

    typedef enum logic [0:0] {
        OP_SQRT,
        OP_DIV
    } asc_op_t;

    typedef struct packed {
        logic        start;
        asc_op_t     op;
        logic [31:0] operand;
        logic [31:0] divisor;
    } asc_req_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] result;
    } asc_resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DETECT,
        ST_DIV_WAIT,
        ST_OUT
    } asc_state_t;

endpackage

// ===== rtl/core/asc_iter_unit.sv =====
module asc_iter_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  asc_pkg::asc_req_t req,
    output asc_pkg::asc_resp_t resp
);
    import asc_pkg::*;

    logic [33:0]       rem_reg, rem_next;
    logic [31:0]       work_reg, work_next;
    logic [31:0]       div_reg, div_next;
    logic [RATE_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    asc_op_t           op_reg, op_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [33:0] rem_sh;
    logic [33:0] sub;
    logic [34:0] diff;
    logic        ge;

    // one shift-subtract step, shared by root and divide
    always_comb begin
        if (op_reg == OP_SQRT) begin
            rem_sh = {rem_reg[31:0], work_reg[31:30]};
            sub    = {16'b0, quo_reg[15:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[32:0], work_reg[31]};
            sub    = {2'b0, div_reg};
        end
        diff = {1'b0, rem_sh} - {1'b0, sub};
        ge   = ~diff[34];
    end

    always_comb begin
        rem_next  = rem_reg;
        work_next = work_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = '0;
            op_next   = req.op;
            div_next  = req.divisor;
            busy_next = 1'b1;
            if (req.op == OP_SQRT) begin
                work_next = req.operand;
                cnt_next  = CNT_W'(SQRT_STEPS);
            end else begin
                work_next = {req.operand[RATE_W-1:0], (32-RATE_W)'(0)};
                cnt_next  = CNT_W'(DIV_STEPS);
            end
        end else if (busy_reg) begin
            rem_next  = ge ? diff[33:0] : rem_sh;
            quo_next  = {quo_reg[RATE_W-2:0], ge};
            work_next = (op_reg == OP_SQRT) ? {work_reg[29:0], 2'b00}
                                            : {work_reg[30:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        work_reg <= work_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        op_reg   <= op_next;
    end

    assign resp.done   = done_reg;
    assign resp.result = quo_reg;

endmodule

// ===== rtl/core/accel_step_counter.sv =====
// accel_step_counter: pedometer on a stream of 3-axis accelerometer samples
//
// s_ channel: one beat per sample (x, y, z in Q3.12 plus a ms timestamp).
// m_ channel: one beat per sample with the step count, step and save flags,
// the step rate (16ths of a step per minute) and the smoothed magnitude.
// apb port: register 0 at address 0 holds the 8-bit hysteresis threshold.
//
// one sample is handled at a time. the squares go through one 16x16
// multiplier in turn, x, y then z; the root (16 steps) and the rate divide
// (20 steps) run on one shared shift-subtract unit; a step with an earlier
// step time and a nonzero interval also runs the rate divide. the next
// sample can be taken in the cycle after its result is loaded.
//
// the result sits in an output register; a new sample is accepted while it
// waits. if the receiver stalls, the following result waits in the
// sequencer and s_ready stays low until the output register frees up.
// reset clears the count, the filter and the detector to the up phase and
// sets the threshold to 45.
module accel_step_counter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  asc_pkg::asc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output asc_pkg::asc_out_t  m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import asc_pkg::*;

    asc_state_t state_reg, state_next;

    asc_in_t           in_reg, in_next;
    logic [7:0]        threshold_reg, threshold_next;
    logic [31:0]       sumsq_reg, sumsq_next;
    logic [15:0]       filt_reg, filt_next;
    logic              phase_reg, phase_next;
    logic [31:0]       count_reg, count_next;
    logic [SAVE_W-1:0] mod_reg, mod_next;
    logic [31:0]       last_reg, last_next;
    logic              have_reg, have_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic              rate_ok_reg, rate_ok_next;
    logic              seen_reg, seen_next;
    logic              save_reg, save_next;
    asc_out_t          out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    asc_req_t  req;
    asc_resp_t resp;

    logic              accept;
    logic              out_load;
    logic              cfg_write;
    logic signed [15:0] axis;
    logic [15:0]       axis_abs;
    logic [31:0]       prod;
    logic [CMP_W-1:0]  lvl;
    logic [CMP_W-1:0]  thr_term;
    logic              fall;
    logic              rise;
    logic              step_fire;
    logic [31:0]       dt;
    logic              div_go;
    logic [16:0]       filt_sum;

    asc_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .resp    (resp)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_THRESHOLD) ? 32'(threshold_reg) : 32'b0;

    always_comb begin
        threshold_next = threshold_reg;
        if (cfg_write && paddr[2] == REG_THRESHOLD) begin
            threshold_next = pwdata[7:0];
        end
    end

    // square of one axis per cycle
    always_comb begin
        case (state_reg)
            ST_SQ_X: axis = in_reg.accel_x;
            ST_SQ_Y: axis = in_reg.accel_y;
            default: axis = in_reg.accel_z;
        endcase
        axis_abs = axis[15] ? 16'(-axis) : axis;
        prod     = 32'(axis_abs) * 32'(axis_abs);
    end

    // detector terms
    assign lvl       = CMP_W'(filt_reg) * CMP_W'(THRESH_DIVISOR);
    assign thr_term  = CMP_W'(threshold_reg) * CMP_W'(ONE_G_SCALE);
    assign fall      = (lvl + thr_term) < CMP_W'(ONE_TERM);
    assign rise      = lvl > (CMP_W'(ONE_TERM) + thr_term);
    assign step_fire = !phase_reg && fall;
    assign dt        = in_reg.timestamp_ms - last_reg;
    assign div_go    = (state_reg == ST_DETECT) && step_fire && have_reg && (dt != 32'b0);
    assign filt_sum  = 17'(resp.result[15:0]) + 17'(filt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SQ_X;
            ST_SQ_X:      state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SQ_Z;
            ST_SQ_Z:      state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (resp.done) state_next = ST_DETECT;
            ST_DETECT:    state_next = div_go ? ST_DIV_WAIT : ST_OUT;
            ST_DIV_WAIT:  if (resp.done) state_next = ST_OUT;
            ST_OUT:       if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready     = 1'b0;
        out_load    = 1'b0;
        req.start   = 1'b0;
        req.op      = OP_SQRT;
        req.operand = sumsq_reg;
        req.divisor = dt;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_ROOT_GO: req.start = 1'b1;
            ST_DETECT: begin
                req.op      = OP_DIV;
                req.operand = 32'(RATE_NUMERATOR);
                req.start   = div_go;
            end
            ST_OUT: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // datapath
    always_comb begin
        in_next      = in_reg;
        sumsq_next   = sumsq_reg;
        filt_next    = filt_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        mod_next     = mod_reg;
        last_next    = last_reg;
        have_next    = have_reg;
        rate_next    = rate_reg;
        rate_ok_next = rate_ok_reg;
        seen_next    = seen_reg;
        save_next    = save_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (accept) begin
            in_next   = s_data;
            seen_next = 1'b0;
            save_next = 1'b0;
        end

        case (state_reg)
            ST_SQ_X: sumsq_next = prod;
            ST_SQ_Y, ST_SQ_Z: sumsq_next = sumsq_reg + prod;
            ST_ROOT_WAIT: if (resp.done) filt_next = filt_sum[16:1];
            ST_DETECT: begin
                if (step_fire) begin
                    phase_next = 1'b1;
                    count_next = count_reg + 32'd1;
                    seen_next  = 1'b1;
                    // a wrap of the count to zero is a multiple too
                    if (count_reg == '1) begin
                        mod_next = '0;
                    end else if (mod_reg == SAVE_W'(SAVE_INTERVAL - 1)) begin
                        mod_next = '0;
                    end else begin
                        mod_next = mod_reg + SAVE_W'(1);
                    end
                    save_next = (count_reg == '1) || (mod_reg == SAVE_W'(SAVE_INTERVAL - 1));
                    if (have_reg && dt == 32'b0) begin
                        rate_next    = RATE_W'(RATE_NUMERATOR);
                        rate_ok_next = 1'b1;
                    end
                    last_next = in_reg.timestamp_ms;
                    have_next = 1'b1;
                end else if (phase_reg && rise) begin
                    phase_next = 1'b0;
                end
            end
            ST_DIV_WAIT: begin
                if (resp.done) begin
                    rate_next    = resp.result;
                    rate_ok_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            out_next.step_total         = count_reg;
            out_next.step_seen          = seen_reg;
            out_next.save_due           = save_reg;
            out_next.step_rate          = rate_reg;
            out_next.rate_valid         = rate_ok_reg;
            out_next.smoothed_magnitude = filt_reg;
            m_valid_next                = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            threshold_reg <= 8'(THRESH_RESET);
            filt_reg      <= '0;
            phase_reg     <= 1'b0;
            count_reg     <= '0;
            mod_reg       <= '0;
            last_reg      <= '0;
            have_reg      <= 1'b0;
            rate_reg      <= '0;
            rate_ok_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            threshold_reg <= threshold_next;
            filt_reg      <= filt_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            mod_reg       <= mod_next;
            last_reg      <= last_next;
            have_reg      <= have_next;
            rate_reg      <= rate_next;
            rate_ok_reg   <= rate_ok_next;
            m_valid_reg   <= m_valid_next;
        end
        in_reg    <= in_next;
        sumsq_reg <= sumsq_next;
        seen_reg  <= seen_next;
        save_reg  <= save_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // a new sample always starts with the x square
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_SQ_X)
        else $error("accepted sample did not start the sequence");

    // the shared unit only finishes while the sequencer waits for it
    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        resp.done |-> (state_reg == ST_ROOT_WAIT || state_reg == ST_DIV_WAIT))
        else $error("iteration unit finished outside a wait state");

    // a save beat is always a step beat
    a_save_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.save_due |-> out_reg.step_seen)
        else $error("save flag without a step");

    // a rate needs an earlier step time
    a_rate_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        rate_ok_reg |-> have_reg)
        else $error("rate valid before any step time was kept");

    // the save counter stays below its interval
    a_mod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_reg < SAVE_W'(SAVE_INTERVAL))
        else $error("save counter out of range");

    // a step in the detector bumps the count by one
    a_step_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DETECT && step_fire |=> count_reg == $past(count_reg) + 32'd1)
        else $error("step did not advance the count");

endmodule

// ===== sim/tb_accel_step_counter.sv =====
`timescale 1ns / 100ps

module tb_accel_step_counter;
    import asc_pkg::*;

    localparam logic [2:0] ADDR_THRESHOLD = 3'(4 * REG_THRESHOLD);
    // next register slot, nothing decoded there
    localparam logic [2:0] ADDR_SPARE     = 3'd4;
    localparam int         MAX_PRINTED    = 50;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic        s_ready;
    asc_in_t     s_data   = '0;
    logic        m_valid;
    logic        m_ready  = 1'b0;
    asc_out_t    m_data;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [7:0]        thresh_cfg      = 8'(THRESH_RESET);
    logic [15:0]       level_q         = '0;
    logic              down_phase      = 1'b0;
    logic [31:0]       step_tally      = '0;
    logic [31:0]       prev_step_ms    = '0;
    logic              prev_step_known = 1'b0;
    logic [RATE_W-1:0] rate_q          = '0;
    logic              rate_known      = 1'b0;

    asc_out_t    pending_reports[$];
    asc_out_t    want_report;
    logic [31:0] ts_now        = '0;
    int          burst_left    = 0;
    int          stall_pct     = 0;
    int          stall_span    = 0;
    int          samples_sent  = 0;
    int          reports_seen  = 0;
    int          steps_seen    = 0;
    int          saves_seen    = 0;
    int          thresholds_run = 0;
    int          error_count   = 0;

    accel_step_counter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    task automatic report_fault(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t beat %0d: %s", $time, reports_seen, msg);
    endtask

    function automatic asc_out_t pedometer_predict(input asc_in_t smp);
        asc_out_t         res;
        longint           comp [3];
        longint unsigned  sumsq;
        longint unsigned  root;
        longint unsigned  trial;
        longint unsigned  lvl_term;
        longint unsigned  thr_term;
        longint unsigned  one_term;
        logic [16:0]      sum17;
        logic [31:0]      dt;
        comp[0] = $signed(smp.accel_x);
        comp[1] = $signed(smp.accel_y);
        comp[2] = $signed(smp.accel_z);
        sumsq = 0;
        for (int a = 0; a < 3; a++) begin
            if (comp[a] < 0)
                comp[a] = -comp[a];
            sumsq += longint'(comp[a] * comp[a]);
        end
        // bitwise floor root, msb first
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sumsq)
                root = trial;
        end
        sum17   = {1'b0, 16'(root)} + {1'b0, level_q};
        level_q = sum17[16:1];

        lvl_term = longint'(level_q) * THRESH_DIVISOR;
        thr_term = longint'(thresh_cfg) * ONE_G_SCALE;
        one_term = longint'(ONE_G_SCALE) * THRESH_DIVISOR;
        res = '0;
        if (!down_phase) begin
            if (lvl_term + thr_term < one_term) begin
                down_phase     = 1'b1;
                step_tally     = step_tally + 32'd1;
                res.step_seen  = 1'b1;
                res.save_due   = (step_tally % SAVE_INTERVAL) == 0;
                if (prev_step_known) begin
                    dt         = smp.timestamp_ms - prev_step_ms;
                    rate_q     = (dt == 0) ? RATE_W'(RATE_NUMERATOR)
                                           : RATE_W'(32'(RATE_NUMERATOR) / dt);
                    rate_known = 1'b1;
                end
                prev_step_ms    = smp.timestamp_ms;
                prev_step_known = 1'b1;
            end
        end else if (lvl_term > one_term + thr_term) begin
            down_phase = 1'b0;
        end
        res.step_total         = step_tally;
        res.step_rate          = rate_q;
        res.rate_valid         = rate_known;
        res.smoothed_magnitude = level_q;
        return res;
    endfunction

    // sample of roughly the given magnitude along a random axis
    function automatic asc_in_t shaped_sample(input int unsigned mag);
        asc_in_t            smp;
        logic signed [15:0] lead;
        logic signed [15:0] side_a;
        logic signed [15:0] side_b;
        lead = 16'((mag > 32767) ? 32767 : mag);
        if ($urandom_range(1) == 1)
            lead = -lead;
        side_a = $signed(16'($urandom_range(600))) - 16'sd300;
        side_b = $signed(16'($urandom_range(600))) - 16'sd300;
        case ($urandom_range(2))
            0: smp = '{lead, side_a, side_b, ts_now};
            1: smp = '{side_a, lead, side_b, ts_now};
            default: smp = '{side_a, side_b, lead, ts_now};
        endcase
        return smp;
    endfunction

    function automatic asc_in_t noise_sample();
        asc_in_t smp;
        smp.accel_x      = 16'($urandom);
        smp.accel_y      = 16'($urandom);
        smp.accel_z      = 16'($urandom);
        smp.timestamp_ms = ($urandom_range(3) == 0) ? $urandom : ts_now;
        return smp;
    endfunction

    task automatic send_sample(input asc_in_t smp);
        int gap;
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_reports.push_back(pedometer_predict(smp));
        samples_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // high stretch then low stretch; tick is the ms advance per sample
    task automatic gait_cycle(input int hi_n, input int lo_n, input int unsigned tick,
                              input int unsigned hi_top);
        for (int i = 0; i < hi_n + lo_n; i++) begin
            ts_now += tick;
            send_sample(shaped_sample((i < hi_n) ? $urandom_range(hi_top, 7000)
                                                 : $urandom_range(2200)));
        end
    endtask

    task automatic drain_block;
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_THRESHOLD)
            thresh_cfg = data[7:0];
        // return to idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic check_threshold_readback;
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_THRESHOLD;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {24'b0, thresh_cfg})
            report_fault($sformatf("threshold read %0h want %0h", got, thresh_cfg));
    endtask

    task automatic random_walk_phase(input int n_items);
        int          first;
        int unsigned tick;
        int          pick;
        first = samples_sent;
        while (samples_sent - first < n_items) begin
            if ($urandom_range(99) < 80) begin
                pick = $urandom_range(99);
                if (pick < 8)
                    tick = 0;
                else if (pick < 12)
                    tick = $urandom_range(2000000, 300000);
                else
                    tick = $urandom_range(120, 5);
                if ($urandom_range(99) < 4)
                    ts_now = 32'hFFFF_FFFF - $urandom_range(400);
                gait_cycle($urandom_range(4, 1), $urandom_range(5, 1), tick,
                           $urandom_range(20000, 7000));
            end else begin
                repeat ($urandom_range(3, 1)) send_sample(noise_sample());
            end
        end
    endtask

    task automatic test_reset_value;
        check_threshold_readback;
    endtask

    task automatic test_field_extremes;
        // all-zero sample drops the level straight through the lower bound
        send_sample('{16'sh0000, 16'sh0000, 16'sh0000, 32'd0});
        send_sample('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd5});
        send_sample('{16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF});
        send_sample('{16'sh7FFF, 16'sh8000, 16'shFFFF, 32'd7});
    endtask

    task automatic test_step_timing;
        ts_now = 32'd1000;
        gait_cycle(2, 4, 0, 12000);
        // same timestamp again, saturated rate
        gait_cycle(2, 4, 0, 12000);
        ts_now = 32'hFFFF_FFF0;
        gait_cycle(2, 4, 0, 12000);
        // interval across the timestamp wrap
        ts_now = 32'd16;
        gait_cycle(2, 4, 0, 12000);
    endtask

    task automatic test_ignored_register;
        drain_block;
        apb_write(ADDR_SPARE, 32'h0000_00C8);
        check_threshold_readback;
        repeat (3) gait_cycle(2, 4, 80, 12000);
    endtask

    task automatic test_threshold_sweep;
        int unsigned sweep [5];
        int          span;
        sweep = '{0, 255, 1, $urandom_range(120, 2), 45};
        foreach (sweep[i]) begin
            drain_block;
            apb_write(ADDR_THRESHOLD, sweep[i]);
            check_threshold_readback;
            thresholds_run++;
            span = (sweep[i] == 255) ? 100 : 200;
            random_walk_phase(span);
        end
    endtask

    // receiver backpressure; the stall duty is redrawn whenever stall_span runs out
    always @(posedge aclk) begin
        if (stall_span == 0) begin
            case ($urandom_range(4))
                0, 1: stall_pct <= 0;
                2: stall_pct <= 30;
                3: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
            stall_span <= $urandom_range(200, 20);
        end else begin
            stall_span <= stall_span - 1;
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                report_fault("result beat with nothing expected");
            end else begin
                want_report = pending_reports.pop_front();
                if (m_data.step_total !== want_report.step_total)
                    report_fault($sformatf("step_total %0d want %0d",
                                           m_data.step_total, want_report.step_total));
                if (m_data.step_seen !== want_report.step_seen)
                    report_fault($sformatf("step_seen %b want %b",
                                           m_data.step_seen, want_report.step_seen));
                if (m_data.save_due !== want_report.save_due)
                    report_fault($sformatf("save_due %b want %b",
                                           m_data.save_due, want_report.save_due));
                if (m_data.step_rate !== want_report.step_rate)
                    report_fault($sformatf("step_rate %0d want %0d",
                                           m_data.step_rate, want_report.step_rate));
                if (m_data.rate_valid !== want_report.rate_valid)
                    report_fault($sformatf("rate_valid %b want %b",
                                           m_data.rate_valid, want_report.rate_valid));
                if (m_data.smoothed_magnitude !== want_report.smoothed_magnitude)
                    report_fault($sformatf("smoothed_magnitude %0d want %0d",
                                           m_data.smoothed_magnitude,
                                           want_report.smoothed_magnitude));
                if (want_report.step_seen)
                    steps_seen++;
                if (want_report.save_due)
                    saves_seen++;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_value;
        test_field_extremes;
        test_step_timing;
        test_ignored_register;
        test_threshold_sweep;

        drain_block;
        repeat (60) @(posedge aclk);

        $display("%0d samples sent, %0d result beats checked", samples_sent, reports_seen);
        $display("%0d steps and %0d save flags over %0d threshold settings",
                 steps_seen, saves_seen, thresholds_run + 1);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout: block stopped responding");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/asc_pkg.sv
rtl/core/asc_iter_unit.sv
rtl/core/accel_step_counter.sv
sim/tb_accel_step_counter.sv
